/* rtl/jtte_pkg.sv */
// Shared types, codes and byte helpers for the JSON token text emitter.
package jtte_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int DEPTH_W   = 4;
  localparam int LVL_W     = 3;
  localparam int SPC_W     = 6;

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

  // event opcodes
  localparam logic [3:0] OP_OBJ_OPEN  = 4'd0;
  localparam logic [3:0] OP_OBJ_CLOSE = 4'd1;
  localparam logic [3:0] OP_ARR_OPEN  = 4'd2;
  localparam logic [3:0] OP_ARR_CLOSE = 4'd3;
  localparam logic [3:0] OP_STR_OPEN  = 4'd4;
  localparam logic [3:0] OP_STR_BYTE  = 4'd5;
  localparam logic [3:0] OP_STR_CLOSE = 4'd6;
  localparam logic [3:0] OP_RAW_OPEN  = 4'd7;
  localparam logic [3:0] OP_BOOL      = 4'd8;

  // status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_CLOSE_ROOT   = 3'd1;
  localparam logic [2:0] ST_WRONG_CLOSER = 3'd2;
  localparam logic [2:0] ST_KEY_NOT_STR  = 3'd3;
  localparam logic [2:0] ST_SECOND_ROOT  = 3'd4;
  localparam logic [2:0] ST_DEPTH_OVF    = 3'd5;
  localparam logic [2:0] ST_DANGLING_KEY = 3'd6;

  // config register indexes
  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_INDENT = 1'b1;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_A_LC   = 8'h61;
  localparam logic [7:0] CH_B_LC   = 8'h62;
  localparam logic [7:0] CH_E_LC   = 8'h65;
  localparam logic [7:0] CH_F_LC   = 8'h66;
  localparam logic [7:0] CH_L_LC   = 8'h6C;
  localparam logic [7:0] CH_N_LC   = 8'h6E;
  localparam logic [7:0] CH_R_LC   = 8'h72;
  localparam logic [7:0] CH_S_LC   = 8'h73;
  localparam logic [7:0] CH_T_LC   = 8'h74;
  localparam logic [7:0] CH_U_LC   = 8'h75;

  typedef enum logic [2:0] {
    PH_IDLE, PH_COMMA, PH_NL, PH_SPACE, PH_BODY, PH_EMPTY
  } phase_t;

  typedef enum logic [1:0] {BK_CHAR, BK_ESC, BK_TRUE, BK_FALSE} body_kind_t;

  // what one event will emit
  typedef struct packed {
    logic             err;
    logic [2:0]       status;
    logic             comma;
    logic [7:0]       sep;
    logic             nl;
    logic [SPC_W-1:0] spaces;
    logic [2:0]       body_len;
    body_kind_t       body_kind;
    logic [7:0]       body_char;
  } plan_t;

  typedef struct packed {
    logic   accept;
    logic   commit;
    logic   emit;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic go;        // output slot free this cycle
    logic last;      // byte of the current phase ends the event
    logic p_err;     // live plan
    logic p_comma;
    logic p_nl;
    logic p_body;
    logic r_nl;      // committed plan
    logic r_spaces;
    logic sp_one;    // one space left
  } stat_t;

  function automatic logic [7:0] esc_code(input logic [7:0] c);
    logic [7:0] e;
    e = CH_NUL;
    if (c < 8'h20) begin
      case (c)
        8'h08:   e = CH_B_LC;
        8'h09:   e = CH_T_LC;
        8'h0A:   e = CH_N_LC;
        8'h0C:   e = CH_F_LC;
        8'h0D:   e = CH_R_LC;
        default: e = CH_U_LC;
      endcase
    end else if (c == CH_QUOTE) begin
      e = CH_QUOTE;
    end else if (c == CH_BSLASH) begin
      e = CH_BSLASH;
    end
    return e;
  endfunction

  function automatic logic [2:0] esc_len(input logic [7:0] c);
    logic [7:0] e;
    e = esc_code(c);
    if (e == CH_NUL) return 3'd1;
    if (e == CH_U_LC) return 3'd6;
    return 3'd2;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + {4'b0, n};
    return 8'h37 + {4'b0, n};  // 'A' - 10
  endfunction

  function automatic logic [7:0] body_byte(input body_kind_t k, input logic [7:0] ch,
                                           input logic [2:0] idx);
    logic [7:0] b;
    logic [7:0] e;
    b = CH_NUL;
    e = esc_code(ch);
    case (k)
      BK_CHAR: b = ch;
      BK_TRUE: begin
        case (idx)
          3'd0:    b = CH_T_LC;
          3'd1:    b = CH_R_LC;
          3'd2:    b = CH_U_LC;
          default: b = CH_E_LC;
        endcase
      end
      BK_FALSE: begin
        case (idx)
          3'd0:    b = CH_F_LC;
          3'd1:    b = CH_A_LC;
          3'd2:    b = CH_L_LC;
          3'd3:    b = CH_S_LC;
          default: b = CH_E_LC;
        endcase
      end
      default: begin
        if (e == CH_NUL) begin
          b = ch;
        end else begin
          case (idx)
            3'd0:    b = CH_BSLASH;
            3'd1:    b = e;
            3'd2:    b = CH_ZERO;
            3'd3:    b = CH_ZERO;
            3'd4:    b = hex_char(ch[7:4]);
            default: b = hex_char(ch[3:0]);
          endcase
        end
      end
    endcase
    return b;
  endfunction

endpackage

/* rtl/jtte_ctrl.sv */
// Event sequencer: walks separator, newline, indent and body phases.
module jtte_ctrl import jtte_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PLAN, S_COMMA, S_NL, S_SPACE, S_BODY, S_EMPTY
  } state_t;

  state_t state_r, state_nxt, after;
  logic   emitting;
  logic   done;

  always_comb begin
    emitting = (state_r != S_IDLE) && (state_r != S_PLAN);
    done     = emitting && stat.go && stat.last;
    in_ready = (state_r == S_IDLE) || done;
    after    = in_valid ? S_PLAN : S_IDLE;

    cmd.accept = in_ready && in_valid;
    cmd.commit = (state_r == S_PLAN);
    cmd.emit   = emitting && stat.go;

    unique case (state_r)
      S_COMMA: cmd.phase = PH_COMMA;
      S_NL:    cmd.phase = PH_NL;
      S_SPACE: cmd.phase = PH_SPACE;
      S_BODY:  cmd.phase = PH_BODY;
      S_EMPTY: cmd.phase = PH_EMPTY;
      default: cmd.phase = PH_IDLE;
    endcase

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PLAN;
      end
      S_PLAN: begin
        if (stat.p_err)        state_nxt = S_EMPTY;
        else if (stat.p_comma) state_nxt = S_COMMA;
        else if (stat.p_nl)    state_nxt = S_NL;
        else if (stat.p_body)  state_nxt = S_BODY;
        else                   state_nxt = S_EMPTY;
      end
      S_COMMA: begin
        if (stat.go) state_nxt = stat.last ? after : (stat.r_nl ? S_NL : S_BODY);
      end
      S_NL: begin
        if (stat.go) state_nxt = stat.last ? after : (stat.r_spaces ? S_SPACE : S_BODY);
      end
      S_SPACE: begin
        if (stat.go) state_nxt = stat.last ? after : (stat.sp_one ? S_BODY : S_SPACE);
      end
      S_BODY, S_EMPTY: begin
        if (stat.go && stat.last) state_nxt = after;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/jtte_dp.sv */
// Datapath: config, nesting stack, byte mode, event plan and output register.
module jtte_dp import jtte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  logic [3:0] in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic       in_raw_is_string,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic [2:0] out_status
);

  typedef enum logic [1:0] {MODE_NONE, MODE_STR, MODE_RAW} mode_t;

  logic               fmt_r;
  logic [2:0]         indent_r;
  logic [DEPTH_W-1:0] depth_r;
  logic               root_r;
  mode_t              mode_r, mode_nxt;

  logic [3:0]         ev_op_r;
  logic [7:0]         ev_data_r;
  logic               ev_raw_r;

  logic               is_arr_r  [MAX_DEPTH];
  logic               has_val_r [MAX_DEPTH];
  logic               odd_r     [MAX_DEPTH];

  plan_t              plan, plan_r;
  logic [SPC_W-1:0]   spc_cnt_r;
  logic [2:0]         idx_r;

  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_bv_r;
  logic               out_last_r;
  logic [2:0]         out_status_r;

  logic [LVL_W-1:0]   top_idx;
  logic               t_arr, t_hv, t_odd, at_root;
  logic [6:0]         prod_up, prod_dn;
  logic [2:0]         v_str, v_nonstr;
  logic               pfx_comma, pfx_nl;
  logic               is_value, is_open, is_close;
  logic               go;
  logic [7:0]         em_byte;
  logic               em_bv, em_last;
  logic [2:0]         em_status;

  assign cfg_ready = 1'b1;
  assign go        = !out_valid_r || out_ready;

  // ---- plan for the latched event against current state
  always_comb begin
    top_idx   = depth_r[LVL_W-1:0] - LVL_W'(1);
    t_arr     = is_arr_r[top_idx];
    t_hv      = has_val_r[top_idx];
    t_odd     = odd_r[top_idx];
    at_root   = (depth_r == '0);
    prod_up   = 7'(depth_r) * 7'(indent_r);
    prod_dn   = 7'(depth_r - DEPTH_W'(1)) * 7'(indent_r);
    pfx_comma = !at_root && t_hv;
    pfx_nl    = !at_root && fmt_r && (!t_hv || t_arr || !t_odd);
    v_str     = (at_root && root_r) ? ST_SECOND_ROOT : ST_OK;
    v_nonstr  = v_str;
    if (!at_root && !t_arr && !t_odd) v_nonstr = ST_KEY_NOT_STR;

    is_value = 1'b0;
    is_open  = 1'b0;
    is_close = 1'b0;

    plan           = '0;
    plan.sep       = (t_arr || !t_odd) ? CH_COMMA : CH_COLON;
    plan.spaces    = prod_up[SPC_W-1:0];
    plan.body_kind = BK_CHAR;

    unique case (ev_op_r) inside
      OP_OBJ_OPEN, OP_ARR_OPEN: begin
        is_value       = 1'b1;
        is_open        = 1'b1;
        plan.status    = v_nonstr;
        if (v_nonstr == ST_OK && depth_r >= DEPTH_LIMIT) plan.status = ST_DEPTH_OVF;
        plan.comma     = pfx_comma;
        plan.nl        = pfx_nl;
        plan.body_len  = 3'd1;
        plan.body_char = (ev_op_r == OP_ARR_OPEN) ? CH_LBRACK : CH_LBRACE;
      end
      OP_OBJ_CLOSE, OP_ARR_CLOSE: begin
        is_close = 1'b1;
        if (at_root)                                plan.status = ST_CLOSE_ROOT;
        else if ((ev_op_r == OP_ARR_CLOSE) != t_arr) plan.status = ST_WRONG_CLOSER;
        else if (ev_op_r == OP_OBJ_CLOSE && t_odd)   plan.status = ST_DANGLING_KEY;
        plan.nl        = fmt_r;
        plan.spaces    = prod_dn[SPC_W-1:0];
        plan.body_len  = 3'd1;
        plan.body_char = (ev_op_r == OP_ARR_CLOSE) ? CH_RBRACK : CH_RBRACE;
      end
      OP_STR_OPEN: begin
        is_value       = 1'b1;
        plan.status    = v_str;
        plan.comma     = pfx_comma;
        plan.nl        = pfx_nl;
        plan.body_len  = 3'd1;
        plan.body_char = CH_QUOTE;
      end
      OP_STR_BYTE: begin
        plan.body_char = ev_data_r;
        if (mode_r == MODE_STR) begin
          plan.body_kind = BK_ESC;
          plan.body_len  = esc_len(ev_data_r);
        end else if (mode_r == MODE_RAW) begin
          plan.body_len  = 3'd1;
        end
      end
      OP_STR_CLOSE: begin
        plan.body_char = CH_QUOTE;
        if (mode_r == MODE_STR) plan.body_len = 3'd1;
      end
      OP_RAW_OPEN: begin
        is_value    = 1'b1;
        plan.status = ev_raw_r ? v_str : v_nonstr;
        plan.comma  = pfx_comma;
        plan.nl     = pfx_nl;
      end
      OP_BOOL: begin
        is_value       = 1'b1;
        plan.status    = v_nonstr;
        plan.comma     = pfx_comma;
        plan.nl        = pfx_nl;
        plan.body_kind = ev_data_r[0] ? BK_TRUE : BK_FALSE;
        plan.body_len  = ev_data_r[0] ? 3'd4 : 3'd5;
      end
      default: ;
    endcase
    plan.err = (plan.status != ST_OK);

    // byte mode: set by clean opens, kept by bytes and raw string closes, else ends
    mode_nxt = MODE_NONE;
    unique case (ev_op_r) inside
      OP_STR_BYTE:  mode_nxt = mode_r;
      OP_STR_CLOSE: mode_nxt = (mode_r == MODE_STR) ? MODE_NONE : mode_r;
      OP_STR_OPEN:  mode_nxt = plan.err ? MODE_NONE : MODE_STR;
      OP_RAW_OPEN:  mode_nxt = plan.err ? MODE_NONE : MODE_RAW;
      default:      mode_nxt = MODE_NONE;
    endcase
  end

  // ---- byte for the current phase
  always_comb begin
    em_byte   = CH_NUL;
    em_bv     = 1'b1;
    em_last   = 1'b0;
    em_status = ST_OK;
    unique case (cmd.phase)
      PH_COMMA: begin
        em_byte = plan_r.sep;
        em_last = !plan_r.nl && (plan_r.body_len == '0);
      end
      PH_NL: begin
        em_byte = CH_NL;
        em_last = (plan_r.spaces == '0) && (plan_r.body_len == '0);
      end
      PH_SPACE: begin
        em_byte = CH_SPACE;
        em_last = (spc_cnt_r == SPC_W'(1)) && (plan_r.body_len == '0);
      end
      PH_BODY: begin
        em_byte = body_byte(plan_r.body_kind, plan_r.body_char, idx_r);
        em_last = (idx_r == plan_r.body_len - 3'd1);
      end
      PH_EMPTY: begin
        em_bv     = 1'b0;
        em_last   = 1'b1;
        em_status = plan_r.status;
      end
      default: em_bv = 1'b0;
    endcase
  end

  always_comb begin
    stat.go       = go;
    stat.last     = em_last;
    stat.p_err    = plan.err;
    stat.p_comma  = plan.comma;
    stat.p_nl     = plan.nl;
    stat.p_body   = (plan.body_len != '0);
    stat.r_nl     = plan_r.nl;
    stat.r_spaces = (plan_r.spaces != '0);
    stat.sp_one   = (spc_cnt_r == SPC_W'(1));
  end

  // ---- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= 1'b0;
      indent_r    <= 3'd4;
      depth_r     <= '0;
      root_r      <= 1'b0;
      mode_r      <= MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FORMAT: fmt_r    <= cfg_data[0];
          CFG_INDENT: indent_r <= cfg_data;
        endcase
      end
      if (cmd.commit) begin
        mode_r <= mode_nxt;
        if (!plan.err) begin
          if (is_value && at_root) root_r <= 1'b1;
          if (is_open)  depth_r <= depth_r + DEPTH_W'(1);
          if (is_close) depth_r <= depth_r - DEPTH_W'(1);
        end
      end
      if (cmd.emit)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---- stack, event, plan and output payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ev_op_r   <= in_opcode;
      ev_data_r <= in_data_byte;
      ev_raw_r  <= in_raw_is_string;
    end
    if (cmd.commit) begin
      plan_r    <= plan;
      spc_cnt_r <= plan.spaces;
      idx_r     <= '0;
      if (!plan.err) begin
        if (is_value && !at_root) begin
          has_val_r[top_idx] <= 1'b1;
          odd_r[top_idx]     <= !t_odd;
        end
        if (is_open) begin
          is_arr_r[depth_r[LVL_W-1:0]]  <= (ev_op_r == OP_ARR_OPEN);
          has_val_r[depth_r[LVL_W-1:0]] <= 1'b0;
          odd_r[depth_r[LVL_W-1:0]]     <= 1'b0;
        end
      end
    end
    if (cmd.emit) begin
      if (cmd.phase == PH_SPACE) spc_cnt_r <= spc_cnt_r - SPC_W'(1);
      if (cmd.phase == PH_BODY)  idx_r     <= idx_r + 3'd1;
      out_byte_r   <= em_byte;
      out_bv_r     <= em_bv;
      out_last_r   <= em_last;
      out_status_r <= em_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule

/* rtl/json_token_text_emitter.sv */
// Top level of the JSON token text emitter: sequencer plus datapath.
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  in      | in_valid/in_ready, opcode, data_byte, raw flag | sink
//  out     | out_valid/out_ready, byte, byte_valid, last, st| source
//  cfg     | cfg_valid/cfg_ready, index, data              | sink
//
// An event first passes the plan state, then emits its output beats (1..63);
// the next event is taken in the cycle its predecessor's last beat enters
// the output register. The single output register sets the pace: one beat
// per cycle while out_ready stays high.
// Reset (rst_n low, synchronous) empties the nesting stack, clears root
// and byte mode, and loads format off, indent 4.
// A stalled out_ready holds the sequencer in place; nothing is dropped.
module json_token_text_emitter import jtte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic       in_raw_is_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic [2:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);

  cmd_t  cmd;    // sequencer -> datapath
  stat_t stat;   // datapath -> sequencer

  // phase sequencer: plan, separator, newline, indent run, body
  jtte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack, config, escaping and the output register
  jtte_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .in_raw_is_string (in_raw_is_string),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  // a beat without a byte is always the closing beat of its event
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last)
    else $error("byte-less beat not marked last");

  // an error beat carries no byte and ends the event
  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_byte_valid && out_last)
    else $error("error status on a data beat");

  // every accepted event passes through the plan state before the next one is taken
  a_plan_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back without planning");

endmodule
